[sv/assert_macros.svh]
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define ASSERT_HOLDS(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("assertion failed");

// The expression must never be true outside reset.
`define ASSERT_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
    else $error("forbidden condition seen");

`endif

[sv/fcpb_pkg.sv]
package fcpb_pkg;

  // Register indexes of the configuration port.
  typedef enum logic [2:0] {
    CFG_CENTER_X  = 3'd0,
    CFG_CENTER_Y  = 3'd1,
    CFG_RADIUS    = 3'd2,
    CFG_FEATHER   = 3'd3,
    CFG_FILL_RED  = 3'd4,
    CFG_FILL_GRN  = 3'd5,
    CFG_FILL_BLUE = 3'd6,
    CFG_INVERT    = 3'd7
  } cfg_reg_e;

  localparam int CFG_DATA_W = 16;
  localparam int CENTER_W   = 16;
  localparam int RADIUS_W   = 14;
  localparam int FEATHER_W  = 7;
  localparam int ALPHA_W    = 9;
  localparam int QUOT_W     = 8;
  localparam int PROD_W     = RADIUS_W + FEATHER_W;

  localparam logic [ALPHA_W-1:0]   ALPHA_ONE   = 9'd256;
  localparam logic [FEATHER_W-1:0] FEATHER_MAX = 7'd100;

  // Division by 100 as a multiply by a rounded-up reciprocal, exact below 2^21.
  localparam int                BAND_SHIFT = 28;
  localparam logic [21:0]       BAND_RECIP = 22'd2684355;

  // One RGBA pixel, red in the lowest byte.
  typedef struct packed {
    logic [7:0] alpha;
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pix_t;

  // Where the distance falls relative to the circle edge.
  typedef struct packed {
    logic in_circle;
    logic outside;
  } zone_t;

endpackage

[sv/fcpb_dist.sv]
module fcpb_dist #(
  parameter int COORD_BITS = 12,
  parameter int D_W        = 16,
  parameter int SUM_W      = 33
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    vld_i,
  input  logic [COORD_BITS-1:0]   px_i,
  input  logic [COORD_BITS-1:0]   py_i,
  input  fcpb_pkg::pix_t          pix_i,
  input  logic [15:0]             cx_i,
  input  logic [15:0]             cy_i,
  output logic                    vld_o,
  output logic [SUM_W-1:0]        sum_o,
  output fcpb_pkg::pix_t          pix_o
);
  import fcpb_pkg::*;

  logic [D_W-1:0]   pxs, pys, cxs, cys, dx_d, dy_d;
  logic [D_W-1:0]   dx_q, dy_q;
  logic [2*D_W-1:0] sqx_q, sqy_q;
  logic [SUM_W-1:0] sum_q;
  pix_t             pix1_q, pix2_q, pix3_q;
  logic [2:0]       vld_q;

  // Absolute offsets in sixteenths of a pixel.
  assign pxs  = D_W'({px_i, 4'b0000});
  assign pys  = D_W'({py_i, 4'b0000});
  assign cxs  = D_W'(cx_i);
  assign cys  = D_W'(cy_i);
  assign dx_d = (pxs >= cxs) ? pxs - cxs : cxs - pxs;
  assign dy_d = (pys >= cys) ? pys - cys : cys - pys;

  // Valid bits of the three stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[1:0], vld_i};
    end
  end

  // Offsets, then squares, then their sum.
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dx_q   <= dx_d;
      dy_q   <= dy_d;
      pix1_q <= pix_i;
      sqx_q  <= dx_q * dx_q;
      sqy_q  <= dy_q * dy_q;
      pix2_q <= pix1_q;
      sum_q  <= SUM_W'(sqx_q) + SUM_W'(sqy_q);
      pix3_q <= pix2_q;
    end
  end

  assign vld_o = vld_q[2];
  assign sum_o = sum_q;
  assign pix_o = pix3_q;

endmodule

[sv/fcpb_isqrt.sv]
module fcpb_isqrt #(
  parameter int N_W    = 33,
  parameter int ROOT_W = 17
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              vld_i,
  input  logic [N_W-1:0]    n_i,
  input  fcpb_pkg::pix_t    pix_i,
  output logic              vld_o,
  output logic [ROOT_W-1:0] root_o,
  output fcpb_pkg::pix_t    pix_o
);
  import fcpb_pkg::*;

  localparam int PAD_W = 2 * ROOT_W;
  localparam int RW    = ROOT_W + 2;

  logic [PAD_W-1:0]  n_q    [ROOT_W];
  logic [RW-1:0]     rem_q  [ROOT_W];
  logic [ROOT_W-1:0] root_q [ROOT_W];
  pix_t              pix_q  [ROOT_W];
  logic              vld_q  [ROOT_W];

  // One root bit per stage, most significant first.
  for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
    logic [PAD_W-1:0]  n_in;
    logic [RW-1:0]     rem_in, rem_sh, trial;
    logic [ROOT_W-1:0] root_in;
    pix_t              pix_in;
    logic              vld_in, take;

    if (k == 0) begin : g_first
      assign n_in    = PAD_W'(n_i);
      assign rem_in  = '0;
      assign root_in = '0;
      assign pix_in  = pix_i;
      assign vld_in  = vld_i;
    end else begin : g_next
      assign n_in    = n_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign pix_in  = pix_q[k-1];
      assign vld_in  = vld_q[k-1];
    end

    // Bring down the next bit pair and try to subtract 4*root+1.
    assign rem_sh = {rem_in[RW-3:0], n_in[PAD_W-1-2*k -: 2]};
    assign trial  = {root_in, 2'b01};
    assign take   = (rem_sh >= trial);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        n_q[k]    <= n_in;
        rem_q[k]  <= take ? rem_sh - trial : rem_sh;
        root_q[k] <= {root_in[ROOT_W-2:0], take};
        pix_q[k]  <= pix_in;
      end
    end
  end

  assign vld_o  = vld_q[ROOT_W-1];
  assign root_o = root_q[ROOT_W-1];
  assign pix_o  = pix_q[ROOT_W-1];

endmodule

[sv/fcpb_alpha.sv]
module fcpb_alpha #(
  parameter int ROOT_W = 17
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            en_i,
  input  logic                            vld_i,
  input  logic [ROOT_W-1:0]               dist_i,
  input  fcpb_pkg::pix_t                  pix_i,
  input  logic [fcpb_pkg::RADIUS_W-1:0]   radius_i,
  input  logic [fcpb_pkg::RADIUS_W-1:0]   band_i,
  input  logic [fcpb_pkg::RADIUS_W:0]     edge_i,
  input  logic                            invert_i,
  output logic                            vld_o,
  output logic [fcpb_pkg::ALPHA_W-1:0]    alpha_o,
  output fcpb_pkg::pix_t                  pix_o
);
  import fcpb_pkg::*;

  localparam int NST = QUOT_W + 1;

  zone_t               zone_q [NST];
  logic [RADIUS_W-1:0] rem_q  [NST];
  logic [QUOT_W-1:0]   quo_q  [NST];
  pix_t                pix_q  [NST];
  logic                vld_q  [NST];
  logic [ALPHA_W-1:0]  alpha_q;
  pix_t                pixa_q;
  logic                vlda_q;

  logic [ROOT_W-1:0]   r_ext, e_ext, diff;
  zone_t               zone_d;
  logic [ALPHA_W-1:0]  alpha_d, alpha_raw;

  // Classify the distance and take the offset into the feather band.
  assign r_ext            = ROOT_W'(radius_i);
  assign e_ext            = ROOT_W'(edge_i);
  assign diff             = dist_i - r_ext;
  assign zone_d.in_circle = (dist_i <= r_ext);
  assign zone_d.outside   = (band_i == '0) || (dist_i >= e_ext);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      zone_q[0] <= zone_d;
      rem_q[0]  <= diff[RADIUS_W-1:0];
      quo_q[0]  <= '0;
      pix_q[0]  <= pix_i;
    end
  end

  // Restoring division of offset*256 by the band, one quotient bit a stage.
  for (genvar k = 1; k < NST; k++) begin : g_div
    logic [RADIUS_W:0] sh;
    logic              ge;

    assign sh = {rem_q[k-1], 1'b0};
    assign ge = (sh >= {1'b0, band_i});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= ge ? RADIUS_W'(sh - {1'b0, band_i}) : sh[RADIUS_W-1:0];
        quo_q[k]  <= {quo_q[k-1][QUOT_W-2:0], ge};
        zone_q[k] <= zone_q[k-1];
        pix_q[k]  <= pix_q[k-1];
      end
    end
  end

  // Final alpha with optional inversion.
  always_comb begin
    if (zone_q[NST-1].in_circle) begin
      alpha_raw = ALPHA_ONE;
    end else if (zone_q[NST-1].outside) begin
      alpha_raw = '0;
    end else begin
      alpha_raw = ALPHA_ONE - ALPHA_W'(quo_q[NST-1]);
    end
    alpha_d = invert_i ? ALPHA_ONE - alpha_raw : alpha_raw;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vlda_q <= 1'b0;
    end else if (en_i) begin
      vlda_q <= vld_q[NST-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      alpha_q <= alpha_d;
      pixa_q  <= pix_q[NST-1];
    end
  end

  assign vld_o   = vlda_q;
  assign alpha_o = alpha_q;
  assign pix_o   = pixa_q;

endmodule

[sv/fcpb_mix.sv]
module fcpb_mix (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          vld_i,
  input  logic [fcpb_pkg::ALPHA_W-1:0]  alpha_i,
  input  fcpb_pkg::pix_t                pix_i,
  input  logic [7:0]                    fill_red_i,
  input  logic [7:0]                    fill_green_i,
  input  logic [7:0]                    fill_blue_i,
  output logic                          vld_o,
  output fcpb_pkg::pix_t                pix_o
);
  import fcpb_pkg::*;

  logic [7:0]         cval [4];
  logic [7:0]         pval [4];
  logic [15:0]        cprod_q [4];
  logic [15:0]        pprod_q [4];
  logic [7:0]         res [4];
  logic [ALPHA_W-1:0] beta;
  logic [1:0]         vld_q;
  pix_t               out_q;

  // Lanes: red, green, blue, then alpha blended against full coverage.
  assign cval[0] = fill_red_i;
  assign cval[1] = fill_green_i;
  assign cval[2] = fill_blue_i;
  assign cval[3] = 8'd255;
  assign pval[0] = pix_i.red;
  assign pval[1] = pix_i.green;
  assign pval[2] = pix_i.blue;
  assign pval[3] = pix_i.alpha;
  assign beta    = ALPHA_ONE - alpha_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[0], vld_i};
    end
  end

  // Weighted sums, shifted down and clamped to a byte.
  for (genvar l = 0; l < 4; l++) begin : g_lane
    logic [16:0] sum;
    assign sum    = 17'(cprod_q[l]) + 17'(pprod_q[l]);
    assign res[l] = (sum[16]) ? 8'd255 : sum[15:8];

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        cprod_q[l] <= 16'(cval[l]) * 16'(alpha_i);
        pprod_q[l] <= 16'(pval[l]) * 16'(beta);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      out_q.red   <= res[0];
      out_q.green <= res[1];
      out_q.blue  <= res[2];
      out_q.alpha <= res[3];
    end
  end

  assign vld_o = vld_q[1];
  assign pix_o = out_q;

endmodule

[sv/feathered_circle_pixel_blend.sv]
// Channel   Dir  Handshake               Contents
// s_axis    in   s_axis_tvalid/tready    pixel request: coordinates and RGBA
// m_axis    out  m_axis_tvalid/tready    blended RGBA pixel
// cfg       in   cfg_we_i (no wait)      register index and write data
//
// One pixel enters per clock while the pipeline advances; the depth is set by the
// bit-per-stage square root and divider chains.
// The whole pipeline advances together whenever the output register is empty
// or being drained; otherwise every stage holds its request.
// Reset clears the valid bits and loads the register defaults; the feather band
// width follows a register write through the product and band registers.
`include "assert_macros.svh"

module feathered_circle_pixel_blend #(
  parameter int COORD_BITS = 12
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // pixel_x, pixel_y, in_red, in_green, in_blue, in_alpha, zero fill
  input  logic [((2*COORD_BITS+32+7)/8)*8-1:0] s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // out_red, out_green, out_blue, out_alpha
  output logic [31:0]                         m_axis_tdata,
  input  logic                                cfg_we_i,
  input  logic [2:0]                          cfg_idx_i,
  input  logic [fcpb_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import fcpb_pkg::*;

  localparam int PX_W   = COORD_BITS + 4;
  localparam int D_W    = (PX_W > 16) ? PX_W : 16;
  localparam int SUM_W  = 2 * D_W + 1;
  localparam int ROOT_W = (SUM_W + 1) / 2;
  localparam int CB     = 2 * COORD_BITS;

  logic [CENTER_W-1:0]  cx_q, cy_q;
  logic [RADIUS_W-1:0]  radius_q, rad_p_q, band_rad_q, band_q;
  logic [FEATHER_W-1:0] feather_q, feather_c;
  logic [7:0]           fill_red_q, fill_green_q, fill_blue_q;
  logic                 invert_q;
  logic [PROD_W-1:0]    prod_q;
  logic [RADIUS_W:0]    edge_pos;
  logic [PROD_W+21:0]   band_wide;

  logic                 en;
  pix_t                 pix_in, pix_s1, pix_s2, pix_s3, pix_out;
  logic                 vld_s1, vld_s2, vld_s3, vld_out;
  logic [SUM_W-1:0]     sum_s1;
  logic [ROOT_W-1:0]    dist_s2;
  logic [ALPHA_W-1:0]   alpha_s3;

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q         <= '0;
      cy_q         <= '0;
      radius_q     <= 14'd800;
      feather_q    <= '0;
      fill_red_q   <= 8'd255;
      fill_green_q <= 8'd255;
      fill_blue_q  <= 8'd255;
      invert_q     <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        CFG_CENTER_X:  cx_q         <= cfg_data_i[CENTER_W-1:0];
        CFG_CENTER_Y:  cy_q         <= cfg_data_i[CENTER_W-1:0];
        CFG_RADIUS:    radius_q     <= cfg_data_i[RADIUS_W-1:0];
        CFG_FEATHER:   feather_q    <= cfg_data_i[FEATHER_W-1:0];
        CFG_FILL_RED:  fill_red_q   <= cfg_data_i[7:0];
        CFG_FILL_GRN:  fill_green_q <= cfg_data_i[7:0];
        CFG_FILL_BLUE: fill_blue_q  <= cfg_data_i[7:0];
        CFG_INVERT:    invert_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Feather band width: radius times clamped percent, then divided by 100.
  assign feather_c = (feather_q > FEATHER_MAX) ? FEATHER_MAX : feather_q;
  assign band_wide = (PROD_W+22)'(prod_q) * (PROD_W+22)'(BAND_RECIP);

  // The radius copy travels two stages so it lines up with its band.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_q     <= '0;
      band_q     <= '0;
      rad_p_q    <= 14'd800;
      band_rad_q <= 14'd800;
    end else begin
      prod_q     <= PROD_W'(radius_q) * PROD_W'(feather_c);
      band_q     <= band_wide[BAND_SHIFT +: RADIUS_W];
      rad_p_q    <= radius_q;
      band_rad_q <= rad_p_q;
    end
  end

  assign edge_pos = {1'b0, band_rad_q} + {1'b0, band_q};

  // The pipeline moves when the output register is free or being taken.
  assign en            = m_axis_tready || !vld_out;
  assign s_axis_tready = en;

  assign pix_in.red   = s_axis_tdata[CB +: 8];
  assign pix_in.green = s_axis_tdata[CB+8 +: 8];
  assign pix_in.blue  = s_axis_tdata[CB+16 +: 8];
  assign pix_in.alpha = s_axis_tdata[CB+24 +: 8];

  fcpb_dist #(
    .COORD_BITS (COORD_BITS),
    .D_W        (D_W),
    .SUM_W      (SUM_W)
  ) u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (s_axis_tvalid),
    .px_i   (s_axis_tdata[COORD_BITS-1:0]),
    .py_i   (s_axis_tdata[CB-1:COORD_BITS]),
    .pix_i  (pix_in),
    .cx_i   (cx_q),
    .cy_i   (cy_q),
    .vld_o  (vld_s1),
    .sum_o  (sum_s1),
    .pix_o  (pix_s1)
  );

  fcpb_isqrt #(
    .N_W    (SUM_W),
    .ROOT_W (ROOT_W)
  ) u_isqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .vld_i  (vld_s1),
    .n_i    (sum_s1),
    .pix_i  (pix_s1),
    .vld_o  (vld_s2),
    .root_o (dist_s2),
    .pix_o  (pix_s2)
  );

  fcpb_alpha #(
    .ROOT_W (ROOT_W)
  ) u_alpha (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .vld_i    (vld_s2),
    .dist_i   (dist_s2),
    .pix_i    (pix_s2),
    .radius_i (band_rad_q),
    .band_i   (band_q),
    .edge_i   (edge_pos),
    .invert_i (invert_q),
    .vld_o    (vld_s3),
    .alpha_o  (alpha_s3),
    .pix_o    (pix_s3)
  );

  fcpb_mix u_mix (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .en_i         (en),
    .vld_i        (vld_s3),
    .alpha_i      (alpha_s3),
    .pix_i        (pix_s3),
    .fill_red_i   (fill_red_q),
    .fill_green_i (fill_green_q),
    .fill_blue_i  (fill_blue_q),
    .vld_o        (vld_out),
    .pix_o        (pix_out)
  );

  assign m_axis_tvalid = vld_out;
  assign m_axis_tdata  = pix_out;

  // The band never exceeds the radius it was computed from.
  `ASSERT_NEVER(a_band_le_radius, clk_i, rst_ni, band_q > band_rad_q)
  // A zero product yields a zero band in the next cycle.
  `ASSERT_HOLDS(a_band_zero, clk_i, rst_ni, (prod_q == '0) |=> (band_q == '0))

endmodule

[sim/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
  import fcpb_pkg::*;

  localparam int CB     = 12;
  localparam int IN_W   = ((2*CB+32+7)/8)*8;
  localparam int LAT    = 40;
  localparam int WD_MAX = 20000;

  typedef struct {
    logic [11:0] px;
    logic [11:0] py;
    logic [7:0]  r;
    logic [7:0]  g;
    logic [7:0]  b;
    logic [7:0]  a;
    logic        known;
    logic [31:0] res;
  } pix_row_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            s_axis_tvalid = 1'b0;
  logic            s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic            m_axis_tvalid;
  logic            m_axis_tready = 1'b0;
  logic [31:0]     m_axis_tdata;
  logic            cfg_we_i = 1'b0;
  logic [2:0]      cfg_idx_i = '0;
  logic [15:0]     cfg_data_i = '0;

  // Shadow copy of the circle settings.
  logic [15:0] sh_cx, sh_cy;
  logic [13:0] sh_rad;
  logic [6:0]  sh_fea;
  logic [7:0]  sh_fr, sh_fg, sh_fb;
  logic        sh_inv;

  logic [31:0] blend_q[$];
  int          mism = 0;
  int          idle_cyc = 0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  bit          hold_recv = 1'b0;
  bit          done = 1'b0;

  feathered_circle_pixel_blend #(.COORD_BITS(CB)) u_top (.*);

  always #2 clk_i = ~clk_i;

  function automatic logic [31:0] isqrt(logic [63:0] n);
    logic [63:0] res;
    logic [63:0] bitv;
    res = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv >>= 2;
    while (bitv != 0) begin
      if (n >= res + bitv) begin
        n -= res + bitv;
        res = (res >> 1) + bitv;
      end else begin
        res >>= 1;
      end
      bitv >>= 2;
    end
    return res[31:0];
  endfunction

  function automatic logic [7:0] mix_ch(logic [7:0] c, logic [7:0] p, logic [8:0] al);
    logic [31:0] s;
    s = c * al + p * (ALPHA_ONE - al);
    return s[15:8];
  endfunction

  // Blended RGBA for one pixel under the current settings.
  function automatic logic [31:0] blend_pixel(pix_row_t p);
    logic [31:0] dx, dy, dist_v, fp, band, rad;
    logic [8:0]  al;
    logic [31:0] oa;
    dx = (p.px << 4) >= sh_cx ? (p.px << 4) - sh_cx : sh_cx - (p.px << 4);
    dy = (p.py << 4) >= sh_cy ? (p.py << 4) - sh_cy : sh_cy - (p.py << 4);
    dist_v = isqrt(64'(dx) * dx + 64'(dy) * dy);
    fp = sh_fea > 100 ? 100 : sh_fea;
    rad = sh_rad;
    band = (rad * fp) / 100;
    if (dist_v <= rad) al = ALPHA_ONE;
    else if (band == 0 || dist_v >= rad + band) al = 0;
    else al = ALPHA_ONE - 9'(((dist_v - rad) * 256) / band);
    if (sh_inv) al = ALPHA_ONE - al;
    oa = (255 * al + p.a * (ALPHA_ONE - al)) >> 8;
    if (oa > 255) oa = 255;
    return {oa[7:0], mix_ch(sh_fb, p.b, al), mix_ch(sh_fg, p.g, al), mix_ch(sh_fr, p.r, al)};
  endfunction

  task automatic set_reg(cfg_reg_e idx, logic [15:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_CENTER_X:  sh_cx  = val;
      CFG_CENTER_Y:  sh_cy  = val;
      CFG_RADIUS:    sh_rad = val[13:0];
      CFG_FEATHER:   sh_fea = val[6:0];
      CFG_FILL_RED:  sh_fr  = val[7:0];
      CFG_FILL_GRN:  sh_fg  = val[7:0];
      CFG_FILL_BLUE: sh_fb  = val[7:0];
      default:       sh_inv = val[0];
    endcase
  endtask

  task automatic drain();
    while (blend_q.size() != 0) @(posedge clk_i);
    repeat (LAT + 5) @(posedge clk_i);
  endtask

  task automatic send_pixel(pix_row_t p);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {p.a, p.b, p.g, p.r, p.py, p.px};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    blend_q.push_back(p.known ? p.res : blend_pixel(p));
  endtask

  task automatic end_burst();
    s_axis_tvalid <= 1'b0;
  endtask

  function automatic pix_row_t rand_pixel(int near);
    pix_row_t p;
    p.known = 1'b0;
    p.res = '0;
    if (near != 0) begin
      p.px = 12'((sh_cx >> 4) + $urandom_range(120) - 60);
      p.py = 12'((sh_cy >> 4) + $urandom_range(120) - 60);
    end else begin
      p.px = 12'($urandom);
      p.py = 12'($urandom);
    end
    p.r = 8'($urandom);
    p.g = 8'($urandom);
    p.b = 8'($urandom);
    p.a = 8'($urandom);
    return p;
  endfunction

  // Receiver side: random stalls, plus a long hold when asked.
  always @(posedge clk_i) begin
    if (hold_recv) m_axis_tready <= 1'b0;
    else m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each output pixel with the oldest prediction.
  always @(posedge clk_i) begin
    logic [31:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (blend_q.size() == 0) begin
        mism++;
        if (mism <= 10) $display("unexpected pixel %h", m_axis_tdata);
      end else begin
        want = blend_q.pop_front();
        for (int c = 0; c < 4; c++)
          if (m_axis_tdata[8*c +: 8] !== want[8*c +: 8]) begin
            mism++;
            if (mism <= 10)
              $display("channel %0d: expected %h got %h", c, want[8*c +: 8],
                       m_axis_tdata[8*c +: 8]);
          end
      end
    end
  end

  // Watchdog on stretches with no accepted request.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || !rst_ni
        || hold_recv || done)
      idle_cyc <= 0;
    else
      idle_cyc <= idle_cyc + 1;
    if (idle_cyc >= WD_MAX) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    pix_row_t dir_tbl[$];
    pix_row_t p;
    int       ph;
    sh_cx = 0; sh_cy = 0; sh_rad = 800; sh_fea = 0;
    sh_fr = 255; sh_fg = 255; sh_fb = 255; sh_inv = 0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed rows under reset settings: origin is inside (fill white, alpha full),
    // far corner is outside (pixel passes through).
    dir_tbl.push_back('{0, 0, 8'h12, 8'h34, 8'h56, 8'h78, 1, 32'hFFFFFFFF});
    dir_tbl.push_back('{4095, 4095, 8'hAB, 8'hCD, 8'hEF, 8'h01, 1, 32'h01EFCDAB});
    dir_tbl.push_back('{4095, 0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1, 32'hFFFFFFFF});
    dir_tbl.push_back('{0, 4095, 8'h00, 8'h00, 8'h00, 8'h00, 1, 32'h00000000});
    dir_tbl.push_back('{50, 0, 8'h00, 8'hFF, 8'h00, 8'hFF, 1, 32'hFFFFFFFF});
    dir_tbl.push_back('{51, 0, 8'h00, 8'hFF, 8'h00, 8'h80, 1, 32'h8000FF00});
    foreach (dir_tbl[i]) send_pixel(dir_tbl[i]);
    end_burst();
    drain();

    // Feathered edge, odd colors, maximum feather and beyond.
    set_reg(CFG_CENTER_X, 16'd1000);
    set_reg(CFG_CENTER_Y, 16'd1000);
    set_reg(CFG_RADIUS, 16'd400);
    set_reg(CFG_FEATHER, 16'd50);
    set_reg(CFG_FILL_RED, 16'd0);
    set_reg(CFG_FILL_GRN, 16'd128);
    set_reg(CFG_FILL_BLUE, 16'd77);
    for (int k = 0; k < 45; k++) begin
      p = rand_pixel(0);
      p.px = 12'(62 + k);
      p.py = 12'd62;
      send_pixel(p);
    end
    end_burst();
    drain();
    set_reg(CFG_FEATHER, 16'd127);
    set_reg(CFG_INVERT, 16'd1);
    for (int k = 0; k < 10; k++) begin
      p = rand_pixel(1);
      send_pixel(p);
    end
    end_burst();
    drain();

    // Random phases with different settings and idling.
    for (ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
        default: begin send_idle_pct = 24; recv_stall_pct = 24; end
      endcase
      set_reg(CFG_CENTER_X, ph == 7 ? 16'hFFFF : 16'($urandom));
      set_reg(CFG_CENTER_Y, ph == 6 ? 16'd0 : 16'($urandom));
      set_reg(CFG_RADIUS, ph == 5 ? 16'h3FFF : (ph == 4 ? 16'd0 : 16'($urandom_range(16000))));
      set_reg(CFG_FEATHER, ph == 3 ? 16'd0 : 16'($urandom_range(127)));
      set_reg(CFG_FILL_RED, 16'($urandom));
      set_reg(CFG_FILL_GRN, 16'($urandom));
      set_reg(CFG_FILL_BLUE, 16'($urandom));
      set_reg(CFG_INVERT, 16'(ph & 1));
      if (ph == 2) begin
        // Long receiver hold while requests keep coming.
        fork
          begin
            hold_recv = 1'b1;
            repeat (300) @(posedge clk_i);
            hold_recv = 1'b0;
          end
        join_none
      end
      for (int k = 0; k < 190; k++) begin
        p = rand_pixel($urandom_range(1));
        send_pixel(p);
        if (k == 100) begin
          end_burst();
          while (blend_q.size() != 0) @(posedge clk_i);
        end
      end
      end_burst();
      drain();
    end

    done = 1'b1;
    if (mism == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+sv
sv/fcpb_pkg.sv
sv/fcpb_dist.sv
sv/fcpb_isqrt.sv
sv/fcpb_alpha.sv
sv/fcpb_mix.sv
sv/feathered_circle_pixel_blend.sv
sim/tb_top.sv
